// ===== sv/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes and priority helpers for the infix to
// prefix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

    // symbol width and default operator stack depth
    localparam int SYM_W               = 8;
    localparam int DEFAULT_STACK_DEPTH = 32;

    // character codes
    localparam logic [SYM_W-1:0] CH_NUL    = 8'h00;
    localparam logic [SYM_W-1:0] CH_TAB    = 8'h09;
    localparam logic [SYM_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [SYM_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [SYM_W-1:0] CH_PCT    = 8'h25;
    localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [SYM_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [SYM_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [SYM_W-1:0] CH_DIG_LO = 8'h30;
    localparam logic [SYM_W-1:0] CH_DIG_HI = 8'h39;
    localparam logic [SYM_W-1:0] CH_UPR_LO = 8'h41;
    localparam logic [SYM_W-1:0] CH_UPR_HI = 8'h5A;
    localparam logic [SYM_W-1:0] CH_LWR_LO = 8'h61;
    localparam logic [SYM_W-1:0] CH_LWR_HI = 8'h7A;

    // operator priority levels
    localparam logic [1:0] RANK_NONE = 2'd0;
    localparam logic [1:0] RANK_ADD  = 2'd1;
    localparam logic [1:0] RANK_MUL  = 2'd2;
    localparam logic [1:0] RANK_POW  = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP_RD,
        ST_OP_DEC,
        ST_PAR_RD,
        ST_PAR_DEC,
        ST_FL_RD,
        ST_FL_DEC,
        ST_FINISH
    } state_t;

    // compare unit result
    typedef struct packed {
        logic higher;
        logic top_is_rparen;
    } cmp_result_t;

    function automatic logic [1:0] sym_rank(input logic [SYM_W-1:0] ch);
        logic [1:0] r;
        r = RANK_NONE;
        if (ch == CH_DOLLAR) begin
            r = RANK_POW;
        end else if (ch == CH_STAR || ch == CH_SLASH || ch == CH_PCT) begin
            r = RANK_MUL;
        end else if (ch == CH_PLUS || ch == CH_MINUS) begin
            r = RANK_ADD;
        end
        return r;
    endfunction

    function automatic logic sym_is_operand(input logic [SYM_W-1:0] ch);
        return (ch >= CH_DIG_LO && ch <= CH_DIG_HI) ||
               (ch >= CH_UPR_LO && ch <= CH_UPR_HI) ||
               (ch >= CH_LWR_LO && ch <= CH_LWR_HI);
    endfunction

endpackage

`default_nettype wire

// ===== sv/itp_stack.sv =====
// ----------------------------------------------------------------------------
// itp_stack
// Operator stack storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_stack #(
    parameter int DEPTH  = itp_pkg::DEFAULT_STACK_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [ADDR_W-1:0]        wr_addr,
    input  wire logic [itp_pkg::SYM_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0]        rd_addr,
    output logic      [itp_pkg::SYM_W-1:0] rd_data
);
    import itp_pkg::*;

    logic [SYM_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== sv/itp_rank_cmp.sv =====
// ----------------------------------------------------------------------------
// itp_rank_cmp
// Shared compare unit: priority of stack top against the current operator,
// and detection of a stacked closing parenthesis.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_rank_cmp (
    input  wire logic [itp_pkg::SYM_W-1:0] top_sym,
    input  wire logic [itp_pkg::SYM_W-1:0] cur_sym,
    output itp_pkg::cmp_result_t           result
);
    import itp_pkg::*;

    // priority compare and parenthesis check
    always_comb begin
        result.higher        = sym_rank(top_sym) > sym_rank(cur_sym);
        result.top_is_rparen = top_sym == CH_RPAREN;
    end

endmodule

`default_nettype wire

// ===== sv/infix_to_prefix_converter_unit.sv =====
// ----------------------------------------------------------------------------
// infix_to_prefix_converter_unit
// Right-to-left operator stack conversion of an infix expression; the item
// stream read backwards is the prefix form.
// ----------------------------------------------------------------------------
//  channel | dir | tdata         | tlast     | tuser
//  s_      | in  | [7:0] symbol  | last_char | -
//  m_      | out | [7:0] out_sym | run_end   | [0] expr_end, [1] error
//
//  blanks, operands, unknown characters and ')' go from idle straight to
//  the finish state; operators and '(' first pass a stack read and a
//  decide state, and the last item adds a stack flush; each pop repeats
//  the stack read, then compare and pop, except the ')' that closes a '('
//  results pass through a one-deep hold and an output register; a stalled
//  m_ side stops the sequencer only when a result needs to move
//  aresetn clears control state; stack contents are left as they are
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_prefix_converter_unit #(
    parameter int STACK_DEPTH = itp_pkg::DEFAULT_STACK_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] symbol
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_symbol
    output logic            m_tlast,
    output logic [1:0]      m_tuser    // [0] expr_end, [1] error
);
    import itp_pkg::*;

    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);
    localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);

    state_t            state_reg, state_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic              last_reg, last_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [LVL_W-1:0]  rcount_reg, rcount_next;
    logic              err_reg, err_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [SYM_W-1:0]  hold_sym_reg, hold_sym_next;
    logic              out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]  out_sym_reg, out_sym_next;
    logic              out_run_reg, out_run_next;
    logic              out_expr_reg, out_expr_next;
    logic              out_err_reg, out_err_next;

    logic              push_en;
    logic [SYM_W-1:0]  push_data;
    logic [LVL_W-1:0]  level_m1;
    logic [SYM_W-1:0]  top_sym;
    cmp_result_t       cmp;

    logic              out_free, can_emit, full, empty;
    logic              in_blank, in_oper, in_rp, in_lp, in_unknown;
    logic [1:0]        in_rank;
    logic              flush_left, in_err;

    assign level_m1 = level_reg - LVL_ONE;

    // operator stack
    itp_stack #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (push_en),
        .wr_addr (level_reg[ADDR_W-1:0]),
        .wr_data (push_data),
        .rd_addr (level_m1[ADDR_W-1:0]),
        .rd_data (top_sym)
    );

    // shared compare unit
    itp_rank_cmp u_cmp (
        .top_sym (top_sym),
        .cur_sym (sym_reg),
        .result  (cmp)
    );

    // input classification and errors known at accept
    always_comb begin
        in_rank    = sym_rank(s_tdata);
        in_blank   = s_tdata == CH_SPACE || s_tdata == CH_TAB;
        in_oper    = sym_is_operand(s_tdata);
        in_rp      = s_tdata == CH_RPAREN;
        in_lp      = s_tdata == CH_LPAREN;
        in_unknown = !in_blank && !in_oper && !in_rp && !in_lp && in_rank == RANK_NONE;
        full       = level_reg == LVL_FULL;
        empty      = level_reg == '0;
        if (in_rp) begin
            flush_left = 1'b1;
        end else if (in_lp) begin
            flush_left = rcount_reg > LVL_ONE;
        end else begin
            flush_left = rcount_reg != '0;
        end
        in_err = in_unknown || (in_rp && full) || (in_lp && rcount_reg == '0) ||
                 (s_tlast && flush_left);
    end

    assign out_free = !out_valid_reg || m_tready;
    assign can_emit = !hold_valid_reg || out_free;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        sym_next        = sym_reg;
        last_next       = last_reg;
        level_next      = level_reg;
        rcount_next     = rcount_reg;
        err_next        = err_reg;
        hold_valid_next = hold_valid_reg;
        hold_sym_next   = hold_sym_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_sym_next    = out_sym_reg;
        out_run_next    = out_run_reg;
        out_expr_next   = out_expr_reg;
        out_err_next    = out_err_reg;
        push_en         = 1'b0;
        push_data       = sym_reg;
        s_tready        = state_reg == ST_IDLE;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    sym_next   = s_tdata;
                    last_next  = s_tlast;
                    err_next   = err_reg | in_err;
                    state_next = s_tlast ? ST_FL_RD : ST_FINISH;
                    if (in_oper) begin
                        hold_valid_next = 1'b1;
                        hold_sym_next   = s_tdata;
                    end else if (in_rp) begin
                        if (!full) begin
                            push_en     = 1'b1;
                            push_data   = s_tdata;
                            level_next  = level_reg + LVL_ONE;
                            rcount_next = rcount_reg + LVL_ONE;
                        end
                    end else if (in_rank != RANK_NONE) begin
                        state_next = ST_OP_RD;
                    end else if (in_lp) begin
                        state_next = ST_PAR_RD;
                    end
                end
            end
            ST_OP_RD: begin
                state_next = ST_OP_DEC;
            end
            ST_OP_DEC: begin
                if (!empty && cmp.higher) begin
                    if (can_emit) begin
                        if (hold_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_sym_next   = hold_sym_reg;
                            out_run_next   = 1'b0;
                            out_expr_next  = 1'b0;
                            out_err_next   = err_reg;
                        end
                        hold_valid_next = 1'b1;
                        hold_sym_next   = top_sym;
                        level_next      = level_m1;
                        state_next      = ST_OP_RD;
                    end
                end else begin
                    if (full) begin
                        err_next = 1'b1;
                    end else begin
                        push_en    = 1'b1;
                        level_next = level_reg + LVL_ONE;
                    end
                    state_next = last_reg ? ST_FL_RD : ST_FINISH;
                end
            end
            ST_PAR_RD: begin
                state_next = ST_PAR_DEC;
            end
            ST_PAR_DEC: begin
                if (empty) begin
                    state_next = last_reg ? ST_FL_RD : ST_FINISH;
                end else if (cmp.top_is_rparen) begin
                    level_next  = level_m1;
                    rcount_next = rcount_reg - LVL_ONE;
                    state_next  = last_reg ? ST_FL_RD : ST_FINISH;
                end else if (can_emit) begin
                    if (hold_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_sym_next   = hold_sym_reg;
                        out_run_next   = 1'b0;
                        out_expr_next  = 1'b0;
                        out_err_next   = err_reg;
                    end
                    hold_valid_next = 1'b1;
                    hold_sym_next   = top_sym;
                    level_next      = level_m1;
                    state_next      = ST_PAR_RD;
                end
            end
            ST_FL_RD: begin
                state_next = ST_FL_DEC;
            end
            ST_FL_DEC: begin
                if (empty) begin
                    state_next = ST_FINISH;
                end else if (cmp.top_is_rparen) begin
                    level_next  = level_m1;
                    rcount_next = rcount_reg - LVL_ONE;
                    state_next  = ST_FL_RD;
                end else if (can_emit) begin
                    if (hold_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_sym_next   = hold_sym_reg;
                        out_run_next   = 1'b0;
                        out_expr_next  = 1'b0;
                        out_err_next   = err_reg;
                    end
                    hold_valid_next = 1'b1;
                    hold_sym_next   = top_sym;
                    level_next      = level_m1;
                    state_next      = ST_FL_RD;
                end
            end
            ST_FINISH: begin
                // last result of the item, or the filler on an empty end
                if (out_free) begin
                    if (hold_valid_reg || last_reg) begin
                        out_valid_next = 1'b1;
                        out_sym_next   = hold_valid_reg ? hold_sym_reg : CH_NUL;
                        out_run_next   = 1'b1;
                        out_expr_next  = last_reg;
                        out_err_next   = err_reg;
                    end
                    hold_valid_next = 1'b0;
                    if (last_reg) begin
                        err_next    = 1'b0;
                        rcount_next = '0;
                    end
                    state_next = ST_IDLE;
                end else if (!hold_valid_reg && !last_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            level_reg      <= '0;
            rcount_reg     <= '0;
            err_reg        <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            level_reg      <= level_next;
            rcount_reg     <= rcount_next;
            err_reg        <= err_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        sym_reg      <= sym_next;
        last_reg     <= last_next;
        hold_sym_reg <= hold_sym_next;
        out_sym_reg  <= out_sym_next;
        out_run_reg  <= out_run_next;
        out_expr_reg <= out_expr_next;
        out_err_reg  <= out_err_next;
    end

    // result port
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sym_reg;
    assign m_tlast  = out_run_reg;
    assign m_tuser  = {out_err_reg, out_expr_reg};

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LVL_FULL)
        else $error("stack level beyond depth");

    a_rparen_count: assert property (@(posedge aclk) disable iff (!aresetn)
        rcount_reg <= level_reg)
        else $error("closing parenthesis count exceeds stack level");

    a_idle_hold_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !hold_valid_reg)
        else $error("pending result left over while idle");

    a_expr_end_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("expression end without run end");

    a_expr_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH && last_reg && out_free |=> level_reg == '0 && !err_reg)
        else $error("stack or error not cleared after expression end");
`endif

endmodule

`default_nettype wire
